FILE: rtl/fbvs_pkg.sv
// Shared types and constants of the frame-bounded value stack.
// Depends on nothing; fbvs_ctrl and the top level refer to it by scoped names.
`default_nettype none

package fbvs_pkg;

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 9;
    localparam int BASE_W   = 8;
    localparam int FILL_W   = 9;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_POP_N    = 3'd2,
        OP_RESERVE  = 3'd3,
        OP_PEEK     = 3'd4,
        OP_READ_IDX = 3'd5
    } t_opcode;

    // Result of one operation as decided at issue time. The slot word and its
    // defined flag come from the value memory's read register in the next cycle.
    // slot_written says the returned slot lies below the high-water mark, so the
    // memory really holds a flag for it.
    typedef struct packed {
        logic              ok;
        logic              overflow;
        logic              slot_read;
        logic              slot_written;
        logic [FILL_W-1:0] fill_level;
    } t_issue;

endpackage

`default_nettype wire

FILE: rtl/fbvs_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fbvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // The read register only changes on a read, so it holds while the user stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/fbvs_ctrl.sv
// Stack pointer, high-water mark, local clear sequencer and operation decode.
// Depends on fbvs_pkg; drives the value memory port of the top level.
`default_nettype none

module fbvs_ctrl #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire fbvs_pkg::t_opcode               i_opcode,
    input  wire logic [fbvs_pkg::DATA_W-1:0]     i_push_data,
    input  wire logic [fbvs_pkg::COUNT_W-1:0]    i_item_count,
    input  wire logic [fbvs_pkg::INDEX_W-1:0]    i_read_index,
    input  wire logic [fbvs_pkg::BASE_W-1:0]     i_frame_base,
    output fbvs_pkg::t_issue                     o_issue,
    output logic                                 o_busy,
    output logic                                 o_ram_en,
    output logic                                 o_ram_we,
    output logic [$clog2(DEPTH)-1:0]             o_ram_addr,
    output logic [VALUE_BITS:0]                  o_ram_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = ((PW > fbvs_pkg::FILL_W) ? PW : fbvs_pkg::FILL_W) + 1;

    logic [PW-1:0] r_sp;
    logic [PW-1:0] n_sp;
    logic [PW-1:0] r_hwm;
    logic [PW-1:0] n_hwm;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;
    logic [PW-1:0] r_clr_left;
    logic [PW-1:0] n_clr_left;

    logic [CW-1:0] w_sp;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_ridx;
    logic [CW-1:0] w_base;
    logic [CW-1:0] w_depth;
    logic [CW-1:0] w_flr;
    logic [CW-1:0] w_next;
    logic [CW-1:0] w_slot;
    logic [CW-1:0] w_rsv_end;
    logic          w_ok;
    logic          w_ovf;
    logic          w_rd;
    logic          w_push;
    logic          w_rsv;
    logic [AW-1:0] w_addr;
    logic          w_fresh;
    logic          w_busy;

    always_comb begin
        w_sp      = CW'(r_sp);
        w_n       = CW'(i_item_count);
        w_ridx    = CW'(i_read_index);
        w_base    = CW'(i_frame_base);
        w_depth   = CW'(DEPTH);
        w_flr     = (w_base < w_depth) ? w_base : '0;
        w_rsv_end = w_sp + w_n;
        w_next    = w_sp;
        w_slot    = w_sp;
        w_ok      = 1'b0;
        w_ovf     = 1'b0;
        w_rd      = 1'b0;
        w_push    = 1'b0;
        w_rsv     = 1'b0;
        case (i_opcode)
            fbvs_pkg::OP_PUSH: begin
                if (w_sp >= w_depth) begin
                    w_ovf = 1'b1;
                end else begin
                    w_push = 1'b1;
                    w_next = w_sp + CW'(1);
                    w_ok   = 1'b1;
                end
            end
            fbvs_pkg::OP_POP: begin
                if (w_sp > w_flr) begin
                    w_next = w_sp - CW'(1);
                    w_slot = w_sp - CW'(1);
                    w_rd   = 1'b1;
                    w_ok   = 1'b1;
                end
            end
            fbvs_pkg::OP_POP_N: begin
                if (w_sp >= w_flr && w_n <= w_sp - w_flr) begin
                    w_next = w_sp - w_n;
                    w_ok   = 1'b1;
                end
            end
            fbvs_pkg::OP_RESERVE: begin
                if (w_rsv_end > w_depth) begin
                    w_ovf = 1'b1;
                end else begin
                    w_rsv  = 1'b1;
                    w_next = w_rsv_end;
                    w_ok   = 1'b1;
                end
            end
            fbvs_pkg::OP_PEEK: begin
                w_slot = (w_sp == '0) ? '0 : w_sp - CW'(1);
                w_rd   = 1'b1;
                w_ok   = 1'b1;
            end
            fbvs_pkg::OP_READ_IDX: begin
                if (w_ridx < w_depth) begin
                    w_slot = w_ridx;
                    w_rd   = 1'b1;
                    w_ok   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        w_addr  = w_slot[AW-1:0];
        // Every slot below the highest stack pointer ever reached has been written by
        // a push or a reserve; slots above it were never touched and are undefined.
        w_fresh = w_rd && (w_slot < CW'(r_hwm));
    end

    assign w_busy = (r_clr_left != '0);

    // A reserve clears its slots one per cycle after its accept edge, lowest first.
    // The top level holds the input off until the run is done.
    always_comb begin
        n_sp       = r_sp;
        n_hwm      = r_hwm;
        n_clr_addr = r_clr_addr;
        n_clr_left = r_clr_left;
        if (w_busy) begin
            n_clr_addr = r_clr_addr + AW'(1);
            n_clr_left = r_clr_left - PW'(1);
        end else if (i_fire) begin
            n_sp = w_next[PW-1:0];
            if (w_next > CW'(r_hwm)) begin
                n_hwm = w_next[PW-1:0];
            end
            if (w_rsv) begin
                n_clr_addr = w_sp[AW-1:0];
                n_clr_left = w_n[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_hwm      <= '0;
            r_clr_addr <= '0;
            r_clr_left <= '0;
        end else begin
            r_sp       <= n_sp;
            r_hwm      <= n_hwm;
            r_clr_addr <= n_clr_addr;
            r_clr_left <= n_clr_left;
        end
    end

    assign o_issue.ok           = w_ok;
    assign o_issue.overflow     = w_ovf;
    assign o_issue.slot_read    = w_rd;
    assign o_issue.slot_written = w_fresh;
    assign o_issue.fill_level   = w_next[fbvs_pkg::FILL_W-1:0];

    assign o_busy = w_busy;

    // The memory word carries the defined flag above the value bits.
    assign o_ram_en    = w_busy || (i_fire && (w_rd || w_push));
    assign o_ram_we    = w_busy || w_push;
    assign o_ram_addr  = w_busy ? r_clr_addr : w_addr;
    assign o_ram_wdata = w_busy ? '0 : {1'b1, i_push_data[VALUE_BITS-1:0]};

endmodule

`default_nettype wire

FILE: rtl/frame_bounded_value_stack_core.sv
// Top level of the frame-bounded operand stack: handshakes, result stage, output register.
// Depends on fbvs_pkg, fbvs_ctrl and fbvs_ram.
// A result passes the stage-one register and then the output register before it can go.
// Throughput: one item per cycle while the output is not stalled; a reserve of n locals
// holds the input off while it clears those slots in the value memory one per cycle.
// Reset (synchronous, active low) empties the stack; the memory is not cleared, slots never
// reached by the stack pointer read as undefined through a high-water mark.
`default_nettype none

module frame_bounded_value_stack_core #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // From bit 0: push_data[63:0], item_count[72:64], read_index[81:73],
    // frame_base[89:82], zero fill[95:90].
    input  wire logic [fbvs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // opcode[2:0].
    input  wire logic [fbvs_pkg::OPCODE_W-1:0]       i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // From bit 0: ok[0], overflow[1], read_data[65:2], read_undefined[66],
    // fill_level[75:67], zero fill[79:76].
    output logic [fbvs_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = fbvs_pkg::DATA_W;

    // The stack pointer updates at the accept edge, and a push writes the value
    // memory at that same edge. The next item's read is issued at the following edge
    // at the soonest, so it always sees the pushed word: no forwarding is needed.
    // A reserve writes its slots after its accept edge while the input is held
    // off, so no read can overlap those writes either.

    logic                  w_in_fire;
    logic                  w_s1_move;
    logic                  w_busy;
    fbvs_pkg::t_issue      w_issue;
    logic                  w_ram_en;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_addr;
    logic [VALUE_BITS:0]   w_ram_wdata;
    logic [VALUE_BITS:0]   w_ram_rdata;
    logic                  w_slot_defined;
    logic [fbvs_pkg::DATA_W-1:0] w_read_data;

    logic                  r_s1_valid;
    fbvs_pkg::t_issue      r_s1;
    logic                  r_out_valid;
    logic [fbvs_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Stage one may hold while the output register is full: no new read is
    // issued then, so the memory's read register keeps the word for it.
    assign w_s1_move       = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !w_busy && (!r_s1_valid || w_s1_move);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    fbvs_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_in_fire),
        .i_opcode     (fbvs_pkg::t_opcode'(i_s_axis_tuser)),
        .i_push_data  (i_s_axis_tdata[63:0]),
        .i_item_count (i_s_axis_tdata[72:64]),
        .i_read_index (i_s_axis_tdata[81:73]),
        .i_frame_base (i_s_axis_tdata[89:82]),
        .o_issue      (w_issue),
        .o_busy       (w_busy),
        .o_ram_en     (w_ram_en),
        .o_ram_we     (w_ram_we),
        .o_ram_addr   (w_ram_addr),
        .o_ram_wdata  (w_ram_wdata)
    );

    fbvs_ram #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (DEPTH)
    ) u_values (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= w_issue;
        end
    end

    // A slot counts as defined only if it was ever written and its stored flag is set.
    // Undefined slots and operations that return nothing read as zero.
    assign w_slot_defined = r_s1.slot_written && w_ram_rdata[VALUE_BITS];
    assign w_read_data    = w_slot_defined ? DW'(w_ram_rdata[VALUE_BITS-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= {4'b0, r_s1.fill_level, r_s1.slot_read && !w_slot_defined,
                           w_read_data, r_s1.overflow, r_s1.ok};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // An overflowing operation never reports success.
    a_ovf_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("overflow reported together with ok");

    // An undefined slot always reads back as zero.
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[66] |-> r_out_data[65:2] == '0)
        else $error("undefined slot returned nonzero data");

    // While stage one waits, the memory read word must not change under it.
    a_rdata_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_move |=> $stable(w_ram_rdata))
        else $error("memory read data changed during a stall");

    // The fill level never exceeds the stack depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (DEPTH > 511) || (32'(r_out_data[75:67]) <= 32'(DEPTH)))
        else $error("fill level beyond stack depth");

endmodule

`default_nettype wire
